// File: rtl/core/gfms_pkg.sv
// Shared constants and types of the gap-filling maximum-subarray block.
package gfms_pkg;

   localparam int SAMPLE_WIDTH_DEF = 16;
   localparam int MAX_GAP_DEF      = 63;
   localparam int SUM_WIDTH_DEF    = 48;

   // Depths of the command queue and of the result queue.
   localparam int CMD_DEPTH = 4;
   localparam int RSP_DEPTH = 4;

   typedef struct packed {
      logic missing;
      logic last;
   } cmd_ctl_type;

endpackage

// File: rtl/core/gap_fill_max_subarray_sum_top.sv
// Top level of the gap-filling maximum-subarray block.
//
//   channel | direction | handshake         | word
//   req     | in        | push / full       | reading, series_last
//   rsp     | out       | pop / empty       | recovered, run_last, series_end, max_sum,
//           |           |                   | gap_overflow
//
// The front takes one input word a cycle while the command queue has room; a missing
// sample inside a short run only bumps a counter and makes no command.
// The back emits one recovered word a cycle while the result queue has room, so a command
// that closes a run of n missing samples yields n + 1 words; that emit sequencer sets
// the sustained rate. Each word is held in the registered result stage before the queue.
// Synchronous reset clears all control state; the back stalls on a full result queue.
module gap_fill_max_subarray_sum_top #(
   parameter int SAMPLE_WIDTH = gfms_pkg::SAMPLE_WIDTH_DEF,
   parameter int MAX_GAP      = gfms_pkg::MAX_GAP_DEF,
   parameter int SUM_WIDTH    = gfms_pkg::SUM_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   output logic                           req_full,
   input  logic signed [SAMPLE_WIDTH-1:0] req_reading,
   input  logic                           req_series_last,
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_recovered,
   output logic                           rsp_run_last,
   output logic                           rsp_series_end,
   output logic signed [SUM_WIDTH-1:0]    rsp_max_sum,
   output logic                           rsp_gap_overflow
);
   import gfms_pkg::*;

   localparam int GAP_WIDTH = $clog2(MAX_GAP + 1);
   localparam int ACC_WIDTH = (SUM_WIDTH > SAMPLE_WIDTH) ? SUM_WIDTH : SAMPLE_WIDTH;
   localparam int CMD_WIDTH = $bits(cmd_ctl_type) + GAP_WIDTH + SAMPLE_WIDTH;
   localparam int RSP_WIDTH = SAMPLE_WIDTH + 3 + SUM_WIDTH;

   logic                    cmd_push, cmd_full, cmd_pop, cmd_empty;
   cmd_ctl_type             cmd_ctl_wr, cmd_ctl_rd;
   logic [GAP_WIDTH-1:0]    cmd_count_wr, cmd_count_rd;
   logic [SAMPLE_WIDTH-1:0] cmd_reading_wr, cmd_reading_rd;
   logic [CMD_WIDTH-1:0]    cmd_wr_data, cmd_rd_data;

   logic                    rsp_push, rsp_full;
   logic [SAMPLE_WIDTH-1:0] b_recovered;
   logic                    b_run_last, b_series_end, b_gap_overflow;
   logic [SUM_WIDTH-1:0]    b_max_sum;
   logic [RSP_WIDTH-1:0]    rsp_wr_data, rsp_rd_data;

   gfms_front #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .MAX_GAP      (MAX_GAP),
      .GAP_WIDTH    (GAP_WIDTH)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_reading     (req_reading),
      .req_series_last (req_series_last),
      .cmd_full        (cmd_full),
      .cmd_push        (cmd_push),
      .cmd_ctl         (cmd_ctl_wr),
      .cmd_count       (cmd_count_wr),
      .cmd_reading     (cmd_reading_wr)
   );

   assign cmd_wr_data = {cmd_ctl_wr, cmd_count_wr, cmd_reading_wr};

   gfms_fifo #(
      .WIDTH (CMD_WIDTH),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_wr_data),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_rd_data),
      .empty     (cmd_empty)
   );

   assign {cmd_ctl_rd, cmd_count_rd, cmd_reading_rd} = cmd_rd_data;

   gfms_back #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .SUM_WIDTH    (SUM_WIDTH),
      .MAX_GAP      (MAX_GAP),
      .GAP_WIDTH    (GAP_WIDTH),
      .ACC_WIDTH    (ACC_WIDTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_empty        (cmd_empty),
      .cmd_ctl          (cmd_ctl_rd),
      .cmd_count        (cmd_count_rd),
      .cmd_reading      (cmd_reading_rd),
      .cmd_pop          (cmd_pop),
      .rsp_full         (rsp_full),
      .rsp_push         (rsp_push),
      .rsp_recovered    (b_recovered),
      .rsp_run_last     (b_run_last),
      .rsp_series_end   (b_series_end),
      .rsp_max_sum      (b_max_sum),
      .rsp_gap_overflow (b_gap_overflow)
   );

   assign rsp_wr_data = {b_recovered, b_run_last, b_series_end, b_gap_overflow, b_max_sum};

   gfms_fifo #(
      .WIDTH (RSP_WIDTH),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_wr_data),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_rd_data),
      .empty     (rsp_empty)
   );

   assign {rsp_recovered, rsp_run_last, rsp_series_end, rsp_gap_overflow, rsp_max_sum} =
      rsp_rd_data;

endmodule

// File: rtl/core/gfms_fifo.sv
// Small register queue with the head word shown while it is not empty.
module gfms_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   localparam int PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]     mem_ff [DEPTH];
   logic [PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0] count_ff, count_in;
   logic                 do_push, do_pop;

   assign full     = (count_ff == CNT_WIDTH'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_push_not_empty: assert property (@(posedge clock) disable iff (reset)
      do_push |=> !empty)
      else $error("queue empty right after a push");

endmodule

// File: rtl/core/gfms_front.sv
// Front part: counts short runs of missing samples and turns every other input word into a command.
module gfms_front #(
   parameter int SAMPLE_WIDTH = gfms_pkg::SAMPLE_WIDTH_DEF,
   parameter int MAX_GAP      = gfms_pkg::MAX_GAP_DEF,
   parameter int GAP_WIDTH    = $clog2(gfms_pkg::MAX_GAP_DEF + 1)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   output logic                           req_full,
   input  logic signed [SAMPLE_WIDTH-1:0] req_reading,
   input  logic                           req_series_last,
   input  logic                           cmd_full,
   output logic                           cmd_push,
   output gfms_pkg::cmd_ctl_type          cmd_ctl,
   output logic [GAP_WIDTH-1:0]           cmd_count,
   output logic [SAMPLE_WIDTH-1:0]        cmd_reading
);
   import gfms_pkg::*;

   localparam logic [SAMPLE_WIDTH-1:0] MISSING_CODE = '1;

   logic [GAP_WIDTH-1:0] gap_ff, gap_in;
   logic                 accept, missing, hold;

   assign req_full = cmd_full;
   assign accept   = req_push && !cmd_full;
   assign missing  = (req_reading == MISSING_CODE);
   // A missing sample is only counted while the run is short and the series goes on.
   assign hold     = missing && !req_series_last && (gap_ff != GAP_WIDTH'(MAX_GAP));

   assign cmd_push        = accept && !hold;
   assign cmd_ctl.missing = missing;
   assign cmd_ctl.last    = req_series_last;
   assign cmd_count       = gap_ff;
   assign cmd_reading     = req_reading;

   always_comb begin
      gap_in = gap_ff;
      if (accept) begin
         gap_in = hold ? gap_ff + 1'b1 : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff <= '0;
      end else begin
         gap_ff <= gap_in;
      end
   end

   a_gap_bound: assert property (@(posedge clock) disable iff (reset)
      gap_ff <= GAP_WIDTH'(MAX_GAP))
      else $error("gap count beyond its limit");

endmodule

// File: rtl/core/gfms_back.sv
// Back part: expands commands into recovered values and tracks the running maximum sum.
module gfms_back #(
   parameter int SAMPLE_WIDTH = gfms_pkg::SAMPLE_WIDTH_DEF,
   parameter int SUM_WIDTH    = gfms_pkg::SUM_WIDTH_DEF,
   parameter int MAX_GAP      = gfms_pkg::MAX_GAP_DEF,
   parameter int GAP_WIDTH    = $clog2(gfms_pkg::MAX_GAP_DEF + 1),
   parameter int ACC_WIDTH    = gfms_pkg::SUM_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           cmd_empty,
   input  gfms_pkg::cmd_ctl_type          cmd_ctl,
   input  logic [GAP_WIDTH-1:0]           cmd_count,
   input  logic [SAMPLE_WIDTH-1:0]        cmd_reading,
   output logic                           cmd_pop,
   input  logic                           rsp_full,
   output logic                           rsp_push,
   output logic [SAMPLE_WIDTH-1:0]        rsp_recovered,
   output logic                           rsp_run_last,
   output logic                           rsp_series_end,
   output logic [SUM_WIDTH-1:0]           rsp_max_sum,
   output logic                           rsp_gap_overflow
);
   import gfms_pkg::*;

   localparam logic signed [ACC_WIDTH:0] SUM_MAX =
      {{(ACC_WIDTH + 2 - SUM_WIDTH){1'b0}}, {(SUM_WIDTH - 1){1'b1}}};
   localparam logic signed [ACC_WIDTH:0] SUM_MIN =
      {{(ACC_WIDTH + 2 - SUM_WIDTH){1'b1}}, {(SUM_WIDTH - 1){1'b0}}};

   // Emit stage state.
   logic [GAP_WIDTH-1:0]           idx_ff;
   logic signed [SAMPLE_WIDTH-1:0] prev_ff;
   logic                           seen_ff;
   logic                           any_ff;
   logic signed [ACC_WIDTH-1:0]    run_ff;

   // Result stage.
   logic                           s1_valid_ff;
   logic [SAMPLE_WIDTH-1:0]        s1_value_ff;
   logic signed [ACC_WIDTH-1:0]    s1_run_ff;
   logic                           s1_first_ff;
   logic                           s1_run_last_ff;
   logic                           s1_end_ff;
   logic                           s1_ovf_ff;
   logic signed [ACC_WIDTH-1:0]    best_ff;

   logic                           s1_ready, fire, final_emit, ovf;
   logic signed [SAMPLE_WIDTH-1:0] x;
   logic signed [SAMPLE_WIDTH:0]   avg_sum;
   logic signed [SAMPLE_WIDTH-1:0] value;
   logic signed [ACC_WIDTH-1:0]    v_ext;
   logic signed [ACC_WIDTH:0]      sum_ext;
   logic signed [ACC_WIDTH:0]      sum_sat;
   logic signed [ACC_WIDTH-1:0]    run_new;
   logic                           v_pos, v_neg;
   logic signed [ACC_WIDTH-1:0]    best_new;

   assign x          = cmd_reading;
   assign s1_ready   = !s1_valid_ff || !rsp_full;
   assign fire       = !cmd_empty && s1_ready;
   assign final_emit = (idx_ff == cmd_count);
   assign cmd_pop    = fire && final_emit;
   assign ovf        = cmd_ctl.missing && (cmd_count == GAP_WIDTH'(MAX_GAP));

   // The upper bits of the widened sum are the floor of its half.
   assign avg_sum = {prev_ff[SAMPLE_WIDTH-1], prev_ff} + {x[SAMPLE_WIDTH-1], x};

   always_comb begin
      if (cmd_ctl.missing) begin
         value = prev_ff;
      end else if (final_emit || !seen_ff) begin
         value = x;
      end else begin
         value = avg_sum[SAMPLE_WIDTH:1];
      end
   end

   assign v_ext   = ACC_WIDTH'(value);
   assign sum_ext = {run_ff[ACC_WIDTH-1], run_ff} + {v_ext[ACC_WIDTH-1], v_ext};
   assign v_neg   = value[SAMPLE_WIDTH-1];
   assign v_pos   = !v_neg && (value != '0);

   always_comb begin
      if (v_pos && (sum_ext > SUM_MAX)) begin
         sum_sat = SUM_MAX;
      end else if (v_neg && (sum_ext < SUM_MIN)) begin
         sum_sat = SUM_MIN;
      end else begin
         sum_sat = sum_ext;
      end
      if (any_ff && (run_ff > 0)) begin
         run_new = sum_sat[ACC_WIDTH-1:0];
      end else begin
         run_new = v_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff  <= '0;
         prev_ff <= '0;
         seen_ff <= 1'b0;
         any_ff  <= 1'b0;
         run_ff  <= '0;
      end else if (fire) begin
         idx_ff <= final_emit ? '0 : idx_ff + 1'b1;
         if (final_emit && cmd_ctl.last) begin
            prev_ff <= '0;
            seen_ff <= 1'b0;
            any_ff  <= 1'b0;
            run_ff  <= '0;
         end else begin
            any_ff <= 1'b1;
            run_ff <= run_new;
            if (!cmd_ctl.missing) begin
               prev_ff <= value;
               if (final_emit) begin
                  seen_ff <= 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= fire;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         s1_value_ff    <= value;
         s1_run_ff      <= run_new;
         s1_first_ff    <= !any_ff;
         s1_run_last_ff <= final_emit;
         s1_end_ff      <= final_emit && cmd_ctl.last;
         s1_ovf_ff      <= ovf;
      end
   end

   always_comb begin
      if (s1_first_ff || (s1_run_ff > best_ff)) begin
         best_new = s1_run_ff;
      end else begin
         best_new = best_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff <= '0;
      end else if (rsp_push) begin
         best_ff <= best_new;
      end
   end

   assign rsp_push         = s1_valid_ff && !rsp_full;
   assign rsp_recovered    = s1_value_ff;
   assign rsp_run_last     = s1_run_last_ff;
   assign rsp_series_end   = s1_end_ff;
   assign rsp_max_sum      = s1_end_ff ? best_new[SUM_WIDTH-1:0] : '0;
   assign rsp_gap_overflow = s1_ovf_ff;

   a_idle_index: assert property (@(posedge clock) disable iff (reset)
      cmd_empty |-> (idx_ff == '0))
      else $error("emit index left over without a command");

   a_end_is_run_last: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_end_ff) |-> s1_run_last_ff)
      else $error("series end on a word that does not close its run");

   a_index_step: assert property (@(posedge clock) disable iff (reset)
      (fire && !final_emit) |=> (idx_ff == $past(idx_ff) + 1'b1))
      else $error("emit index did not advance");

endmodule
